### rtl/core/kbt_pkg.sv
package kbt_pkg;

	localparam int DEF_CAPACITY = 16;

	localparam logic [31:0] HDL_LOW  = 32'h0001_0000;
	localparam logic [31:0] HDL_HIGH = 32'h8000_0000;
	localparam logic [31:0] HDL_ALGN = 32'h0000_0003;

	localparam logic [2:0] FN_INSERT   = 3'd0;
	localparam logic [2:0] FN_ERASE    = 3'd1;
	localparam logic [2:0] FN_FIND_INC = 3'd2;
	localparam logic [2:0] FN_FIND_KEY = 3'd3;
	localparam logic [2:0] FN_CLEAR    = 3'd4;

	typedef enum logic [3:0] {
		ST_INSERTED       = 4'd0,
		ST_INVALID        = 4'd1,
		ST_KEY_CONFLICT   = 4'd2,
		ST_HANDLE_CONFLICT = 4'd3,
		ST_FULL           = 4'd4,
		ST_REMOVED        = 4'd5,
		ST_STALE_INC      = 4'd6,
		ST_STALE_GEN      = 4'd7,
		ST_NOT_FOUND      = 4'd8,
		ST_FOUND          = 4'd9,
		ST_CLEARED        = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] player_key;
		logic [31:0] incarnation;
		logic [31:0] gen_tag;
		logic [31:0] game_handle;
		logic [31:0] vehicle_handle;
		logic [31:0] motion_handle;
		logic [31:0] body_handle;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [63:0] out_key;
		logic [31:0] out_incarnation;
		logic [31:0] out_gen;
		logic [31:0] out_game_handle;
		logic [31:0] out_vehicle_handle;
		logic [31:0] out_motion_handle;
		logic [31:0] out_body_handle;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] inc;
		logic [31:0] gen;
		logic [31:0] h0;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [31:0] h3;
	} entry_t;

	typedef struct packed {
		logic key_eq;
		logic inc_eq;
		logic gen_eq;
		logic hdl_eq;
	} cmp_t;

	function automatic logic plausible(input logic [31:0] h);
		return (h >= HDL_LOW) && (h < HDL_HIGH) && ((h & HDL_ALGN) == 32'd0);
	endfunction

	function automatic entry_t to_entry(input req_t r);
		entry_t e;
		e.key = r.player_key;
		e.inc = r.incarnation;
		e.gen = r.gen_tag;
		e.h0  = r.game_handle;
		e.h1  = r.vehicle_handle;
		e.h2  = r.motion_handle;
		e.h3  = r.body_handle;
		return e;
	endfunction

endpackage

### rtl/core/kbt_store.sv
module kbt_store #(
	parameter int CAPACITY = kbt_pkg::DEF_CAPACITY,
	parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  kbt_pkg::entry_t  wdata,
	input  logic [AW-1:0]    raddr,
	output kbt_pkg::entry_t  rdata
);
	import kbt_pkg::*;

	entry_t mem_q [CAPACITY];

	// write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/kbt_cmp.sv
module kbt_cmp (
	input  kbt_pkg::entry_t req_e,
	input  kbt_pkg::entry_t ent,
	output kbt_pkg::cmp_t   res
);
	import kbt_pkg::*;

	// compare the request against one stored entry
	always_comb begin
		res.key_eq = (ent.key == req_e.key);
		res.inc_eq = (ent.inc == req_e.inc);
		res.gen_eq = (ent.gen == req_e.gen);
		res.hdl_eq = (ent.h0 == req_e.h0) || (ent.h1 == req_e.h1) ||
			(ent.h2 == req_e.h2) || (ent.h3 == req_e.h3);
	end

endmodule

### rtl/core/keyed_binding_table_unique_fields.sv
// Ordered binding table held in a single-port-read memory and walked one entry per cycle by
// a shared compare unit. A command is taken when start is high and busy is low. Each result
// appears for exactly one cycle with done high and cannot be held off; for a command that
// scans, busy stays high until the result. Insert and both finds read each entry in turn
// from the memory; erase scans, then moves each later entry down by one; clear and rejected
// commands finish without a scan. Occupancy reports the entry count after the command.
module keyed_binding_table_unique_fields #(
	parameter int CAPACITY = kbt_pkg::DEF_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kbt_pkg::req_t req,
	output logic          done,
	output kbt_pkg::rsp_t rsp
);
	import kbt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t         state_q, state_d;
	req_t           req_q;
	entry_t         req_e, rdata, wdata, emit_e;
	cmp_t           cmp;
	logic [CW-1:0]  idx_q, idx_d, fill_q, fill_d, wr_idx;
	logic           vld_q, vld_d;
	logic [31:0]    gen_q, gen_d, gen_take, gen_inc;
	logic [AW-1:0]  rd_addr, waddr;
	logic           we, fin, emit, go_scan, go_shift, accept, ins_ok, hit;
	status_t        fin_st;
	logic           done_q;
	rsp_t           rsp_q;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign req_e  = to_entry(req_q);

	kbt_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	kbt_cmp u_cmp (
		.req_e (req_e),
		.ent   (rdata),
		.res   (cmp)
	);

	// insert request checks
	assign ins_ok = (req.player_key != 64'd0) && (req.incarnation != 32'd0) &&
		(req.gen_tag == 32'd0) && plausible(req.game_handle) &&
		plausible(req.vehicle_handle) && plausible(req.motion_handle) &&
		plausible(req.body_handle);

	// generation stamp: skip zero, wrap to one
	always_comb begin
		gen_take = (gen_q == 32'd0) ? 32'd1 : gen_q;
		gen_inc  = gen_take + 32'd1;
		if (gen_inc == 32'd0) begin
			gen_inc = 32'd1;
		end
	end

	// entry under compare matches for this command
	always_comb begin
		case (req_q.func)
			FN_INSERT:   hit = cmp.key_eq || cmp.hdl_eq;
			FN_ERASE:    hit = cmp.key_eq;
			FN_FIND_INC: hit = cmp.key_eq && cmp.inc_eq;
			FN_FIND_KEY: hit = cmp.key_eq;
			default:     hit = 1'b0;
		endcase
	end

	assign wr_idx = idx_q - CW'(2);

	// sequencer outputs
	always_comb begin
		rd_addr  = idx_q[AW-1:0];
		we       = 1'b0;
		waddr    = wr_idx[AW-1:0];
		wdata    = rdata;
		idx_d    = idx_q;
		vld_d    = vld_q;
		fill_d   = fill_q;
		gen_d    = gen_q;
		fin      = 1'b0;
		fin_st   = ST_INVALID;
		emit     = 1'b0;
		emit_e   = rdata;
		go_scan  = 1'b0;
		go_shift = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_d = '0;
					vld_d = 1'b0;
					case (req.func)
						FN_INSERT: begin
							if (ins_ok) go_scan = 1'b1;
							else fin = 1'b1;
						end
						FN_ERASE: begin
							if (req.player_key == 64'd0 || req.incarnation == 32'd0 ||
								req.gen_tag == 32'd0) fin = 1'b1;
							else go_scan = 1'b1;
						end
						FN_FIND_INC, FN_FIND_KEY: go_scan = 1'b1;
						FN_CLEAR: begin
							fill_d = '0;
							fin    = 1'b1;
							fin_st = ST_CLEARED;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (vld_q && hit) begin
					vld_d = 1'b0;
					case (req_q.func)
						FN_INSERT: begin
							fin    = 1'b1;
							fin_st = cmp.key_eq ? ST_KEY_CONFLICT : ST_HANDLE_CONFLICT;
						end
						FN_ERASE: begin
							if (!cmp.inc_eq) begin
								fin    = 1'b1;
								fin_st = ST_STALE_INC;
							end else if (!cmp.gen_eq) begin
								fin    = 1'b1;
								fin_st = ST_STALE_GEN;
							end else begin
								go_shift = 1'b1;
							end
						end
						default: begin
							fin    = 1'b1;
							fin_st = ST_FOUND;
							emit   = 1'b1;
						end
					endcase
				end else if (idx_q < fill_q) begin
					idx_d = idx_q + CW'(1);
					vld_d = 1'b1;
				end else begin
					// end of table reached without a match
					vld_d = 1'b0;
					fin   = 1'b1;
					if (req_q.func == FN_INSERT) begin
						if (fill_q >= CW'(CAPACITY)) begin
							fin_st = ST_FULL;
						end else begin
							we        = 1'b1;
							waddr     = fill_q[AW-1:0];
							wdata     = req_e;
							wdata.gen = gen_take;
							gen_d     = gen_inc;
							fill_d    = fill_q + CW'(1);
							fin_st    = ST_INSERTED;
							emit      = 1'b1;
							emit_e    = wdata;
						end
					end else begin
						fin_st = ST_NOT_FOUND;
					end
				end
			end
			S_SHIFT: begin
				// move each later entry down by one
				we = vld_q;
				if (idx_q < fill_q) begin
					idx_d = idx_q + CW'(1);
					vld_d = 1'b1;
				end else begin
					vld_d  = 1'b0;
					fill_d = fill_q - CW'(1);
					fin    = 1'b1;
					fin_st = ST_REMOVED;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (go_scan) state_d = S_SCAN;
			S_SCAN: begin
				if (fin) state_d = S_IDLE;
				else if (go_shift) state_d = S_SHIFT;
			end
			S_SHIFT: if (fin) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			vld_q   <= 1'b0;
			fill_q  <= '0;
			gen_q   <= 32'd1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			vld_q   <= vld_d;
			fill_q  <= fill_d;
			gen_q   <= gen_d;
			done_q  <= fin;
		end
	end

	// hold the command and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (fin) begin
			rsp_q.status             <= fin_st;
			rsp_q.out_key            <= emit ? emit_e.key : 64'd0;
			rsp_q.out_incarnation    <= emit ? emit_e.inc : 32'd0;
			rsp_q.out_gen            <= emit ? emit_e.gen : 32'd0;
			rsp_q.out_game_handle    <= emit ? emit_e.h0 : 32'd0;
			rsp_q.out_vehicle_handle <= emit ? emit_e.h1 : 32'd0;
			rsp_q.out_motion_handle  <= emit ? emit_e.h2 : 32'd0;
			rsp_q.out_body_handle    <= emit ? emit_e.h3 : 32'd0;
			rsp_q.occupancy          <= 5'(fill_d);
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while still busy");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY)) else $error("fill count beyond capacity");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("accepted command lost");

	a_vld_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !vld_q) else $error("read pending while idle");

endmodule
